@@ rtl/core/pps_pkg.sv @@
`timescale 1ns / 1ps
package pps_pkg;

	// field widths
	localparam int SLOT_W  = 4;
	localparam int ARR_W   = 16;
	localparam int BURST_W = 16;
	localparam int PRIO_W  = 8;
	localparam int TIME_W  = 20;
	localparam int CNT_W   = 5;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [CNT_W-1:0]  PCOUNT_RESET = CNT_W'(1);

	localparam int MAX_PROCS_DEF = 16;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_TICK = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t            req_type;
		logic [SLOT_W-1:0]    slot;
		logic [ARR_W-1:0]     arrival;
		logic [BURST_W-1:0]   burst;
		logic [PRIO_W-1:0]    prio;
	} req_t;

	typedef struct packed {
		logic                 idle;
		logic [SLOT_W-1:0]    ran_slot;
		logic                 finished;
		logic [TIME_W-1:0]    completion_time;
		logic [TIME_W-1:0]    turnaround;
		logic [TIME_W-1:0]    waiting;
		logic [TIME_W-1:0]    response;
		logic                 all_done;
	} rsp_t;

	// one process slot as held in the slot memory
	typedef struct packed {
		logic [ARR_W-1:0]     arrival;
		logic [BURST_W-1:0]   burst;
		logic [PRIO_W-1:0]    prio;
		logic [BURST_W-1:0]   remaining;
		logic [TIME_W-1:0]    first_start;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic start;
		logic rd_en;
		logic update;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage

@@ rtl/core/pps_if.sv @@
`timescale 1ns / 1ps
interface pps_req_if;
	logic          valid;
	logic          ready;
	pps_pkg::req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pps_rsp_if;
	logic          valid;
	logic          ready;
	pps_pkg::rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pps_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [pps_pkg::CNT_W-1:0]  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/core/preemptive_priority_scheduler.sv @@
`timescale 1ns / 1ps
// Preemptive priority scheduler. A load transfer on req writes one process slot
// (arrival, burst, priority) and marks it pending; it gives no result. A tick
// transfer runs one time unit: the slots below the configured count (capped at the
// slot memory depth) are scanned one per cycle out of the slot memory, the highest
// priority arrived pending slot wins (earlier arrival, then lower slot, on ties),
// and one result transfer on rsp reports it, with its timing figures on
// completion. A tick passes through acceptance, a scan of each slot, a read drain
// step and an update step, with scan and drain skipped for a count of zero; the
// update waits while the previous result still sits unaccepted in the output
// register. The slot count on cfg resets to 1 and is meant to be written while
// the block is idle.
module preemptive_priority_scheduler #(
	parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pps_req_if.sink    req,
	pps_rsp_if.source  rsp,
	pps_cfg_if.sink    cfg
);
	import pps_pkg::*;

	localparam int SW = $clog2(MAX_PROCS);
	localparam int CW = $clog2(MAX_PROCS + 1);

	cmd_t           cmd;
	sts_t           sts;
	logic [SW-1:0]  rd_idx;
	logic [CW-1:0]  cnt;

	// sequencer
	pps_ctrl #(
		.MAX_PROCS (MAX_PROCS),
		.SW        (SW),
		.CW        (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req.data.req_type),
		.req_ready (req.ready),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.cfg_ready (cfg.ready),
		.sts       (sts),
		.cmd       (cmd),
		.rd_idx    (rd_idx),
		.cnt       (cnt)
	);

	// slot memory, pick logic and result register
	pps_dp #(
		.MAX_PROCS (MAX_PROCS),
		.SW        (SW),
		.CW        (CW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_idx    (rd_idx),
		.cnt       (cnt),
		.req_data  (req.data),
		.sts       (sts),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp.data)
	);

endmodule

@@ rtl/core/pps_ctrl.sv @@
`timescale 1ns / 1ps
module pps_ctrl #(
	parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
	parameter int SW        = $clog2(MAX_PROCS),
	parameter int CW        = $clog2(MAX_PROCS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  pps_pkg::req_kind_t         req_kind,
	output logic                       req_ready,
	input  logic                       cfg_valid,
	input  logic [pps_pkg::CNT_W-1:0]  cfg_data,
	output logic                       cfg_ready,
	input  pps_pkg::sts_t              sts,
	output pps_pkg::cmd_t              cmd,
	output logic [SW-1:0]              rd_idx,
	output logic [CW-1:0]              cnt
);
	import pps_pkg::*;

	localparam int CAP = (MAX_PROCS > 31) ? 31 : MAX_PROCS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_UPDATE
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     idx_q;
	logic [CNT_W-1:0]  pcount_q;
	logic [CNT_W-1:0]  eff_count;
	logic              req_fire;

	// slot count register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= PCOUNT_RESET;
		end else if (cfg_valid) begin
			pcount_q <= cfg_data;
		end
	end

	// effective count, capped at the slot memory depth
	assign eff_count = (pcount_q > CNT_W'(CAP)) ? CNT_W'(CAP) : pcount_q;
	assign cnt       = CW'(eff_count);

	// handshake and commands
	assign req_ready  = (state_q == S_IDLE);
	assign req_fire   = req_valid && req_ready;
	assign cmd.load   = req_fire && (req_kind == REQ_LOAD);
	assign cmd.start  = req_fire && (req_kind == REQ_TICK);
	assign cmd.rd_en  = (state_q == S_SCAN);
	assign cmd.update = (state_q == S_UPDATE) && !sts.out_busy;
	assign rd_idx     = idx_q[SW-1:0];

	// sequencer: scan one slot per cycle, drain the read pipe, then update; a zero count goes straight to update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						idx_q   <= '0;
						state_q <= (cnt == '0) ? S_UPDATE : S_SCAN;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + CW'(1);
					if (idx_q == cnt - CW'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (!sts.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/pps_dp.sv @@
`timescale 1ns / 1ps
module pps_dp #(
	parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
	parameter int SW        = $clog2(MAX_PROCS),
	parameter int CW        = $clog2(MAX_PROCS + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pps_pkg::cmd_t   cmd,
	input  logic [SW-1:0]   rd_idx,
	input  logic [CW-1:0]   cnt,
	input  pps_pkg::req_t   req_data,
	output pps_pkg::sts_t   sts,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output pps_pkg::rsp_t   rsp_data
);
	import pps_pkg::*;

	// slot memory
	entry_t                 mem [MAX_PROCS];
	logic                   mem_we;
	logic [SW-1:0]          mem_waddr;
	entry_t                 mem_wdata;

	// scan pipeline
	logic                   rd_s1;
	logic [SW-1:0]          addr_s1;
	entry_t                 rdata_s1;

	// running pick
	logic                   found_q;
	logic [SW-1:0]          best_idx_q;
	entry_t                 best_q;
	logic [CW-1:0]          ndone_q;

	logic [MAX_PROCS-1:0]   done_q;
	logic [TIME_W-1:0]      time_q;

	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic                   ld_ok;
	logic [SW-1:0]          ld_addr;
	entry_t                 ld_entry;
	logic                   elig;
	logic                   better;

	logic                   first_run;
	logic [TIME_W-1:0]      start_v;
	logic [BURST_W-1:0]     rem_n;
	logic [TIME_W-1:0]      time_n;
	logic                   fin;
	logic [TIME_W-1:0]      arr_w;
	logic [TIME_W-1:0]      burst_w;
	logic [TIME_W-1:0]      tat;
	logic [TIME_W-1:0]      wt;
	logic [TIME_W-1:0]      rt;
	logic [CW-1:0]          ndone_n;
	entry_t                 wb_entry;

	// load item decode
	assign ld_ok   = (32'(req_data.slot) < 32'(MAX_PROCS));
	assign ld_addr = SW'(req_data.slot);

	always_comb begin
		ld_entry             = '0;
		ld_entry.arrival     = req_data.arrival;
		ld_entry.burst       = req_data.burst;
		ld_entry.prio        = req_data.prio;
		ld_entry.remaining   = req_data.burst;
	end

	// compare of the slot read last cycle against the running pick
	assign elig   = rd_s1 && !done_q[addr_s1] && ({4'b0, rdata_s1.arrival} <= time_q);
	assign better = !found_q || (rdata_s1.prio > best_q.prio) ||
	                ((rdata_s1.prio == best_q.prio) && (rdata_s1.arrival < best_q.arrival));

	// run one time unit on the pick and work out its figures
	assign arr_w     = TIME_W'(best_q.arrival);
	assign burst_w   = TIME_W'(best_q.burst);
	assign first_run = (best_q.remaining == best_q.burst);
	assign start_v   = first_run ? time_q : best_q.first_start;
	assign rem_n     = (best_q.remaining != '0) ? best_q.remaining - BURST_W'(1) : '0;
	assign time_n    = (time_q != TIME_MAX) ? time_q + TIME_W'(1) : time_q;
	assign fin       = found_q && (rem_n == '0);
	assign tat       = time_n - arr_w;
	assign wt        = (tat >= burst_w) ? tat - burst_w : '0;
	assign rt        = start_v - arr_w;
	assign ndone_n   = ndone_q + CW'(fin);

	always_comb begin
		wb_entry             = best_q;
		wb_entry.remaining   = rem_n;
		wb_entry.first_start = start_v;
	end

	// single write port shared by loads and write-back
	assign mem_we    = (cmd.load && ld_ok) || (cmd.update && found_q);
	assign mem_waddr = cmd.load ? ld_addr : best_idx_q;
	assign mem_wdata = cmd.load ? ld_entry : wb_entry;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[rd_idx];
		end
	end

	// read pipe control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1   <= 1'b0;
			addr_s1 <= '0;
		end else begin
			rd_s1   <= cmd.rd_en;
			addr_s1 <= rd_idx;
		end
	end

	// pick tracking and done counting during the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			best_idx_q <= '0;
			ndone_q    <= '0;
		end else if (cmd.start) begin
			found_q <= 1'b0;
			ndone_q <= '0;
		end else if (rd_s1) begin
			if (done_q[addr_s1]) begin
				ndone_q <= ndone_q + CW'(1);
			end
			if (elig && better) begin
				found_q    <= 1'b1;
				best_idx_q <= addr_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (elig && better) begin
			best_q <= rdata_s1;
		end
	end

	// done marks and time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '1;
			time_q <= '0;
		end else begin
			if (cmd.load && ld_ok) begin
				done_q[ld_addr] <= 1'b0;
			end else if (cmd.update && fin) begin
				done_q[best_idx_q] <= 1'b1;
			end
			if (cmd.update) begin
				time_q <= time_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.update) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			rsp_q.idle            <= !found_q;
			rsp_q.ran_slot        <= found_q ? SLOT_W'(best_idx_q) : '0;
			rsp_q.finished        <= fin;
			rsp_q.completion_time <= fin ? time_n : '0;
			rsp_q.turnaround      <= fin ? tat : '0;
			rsp_q.waiting         <= fin ? wt : '0;
			rsp_q.response        <= fin ? rt : '0;
			rsp_q.all_done        <= (ndone_n == cnt);
		end
	end

	assign sts.out_busy = rsp_valid_q && !rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign rsp_data     = rsp_q;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import pps_pkg::*;

	localparam int NUM_SLOTS = MAX_PROCS_DEF;
	localparam int IDLE_PCT = 18;
	localparam int MISMATCH_SHOWN = 10;
	localparam int DRAIN_CYCLES = 24;
	localparam longint unsigned CYCLE_LIMIT = 64'd5_000_000;
	localparam int unsigned PHASE_ITEMS = 210;
	localparam int unsigned PHASE_COUNTS [8] = '{5, 16, 1, 0, 31, 3, 12, 16};
	localparam int CALM_PHASE = 1;

	logic clk;
	logic arst_n;

	pps_req_if req();
	pps_rsp_if rsp();
	pps_cfg_if cfg();

	preemptive_priority_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	// shadow of the process slots and scheduler clock
	logic [ARR_W-1:0]   arr_tab   [NUM_SLOTS];
	logic [BURST_W-1:0] burst_tab [NUM_SLOTS];
	logic [PRIO_W-1:0]  prio_tab  [NUM_SLOTS];
	logic [BURST_W-1:0] left_tab  [NUM_SLOTS];
	logic [TIME_W-1:0]  start_tab [NUM_SLOTS];
	logic               done_mark [NUM_SLOTS];
	logic [TIME_W-1:0]  clock_now;
	logic [CNT_W-1:0]   slot_count;

	req_t req_backlog [$];
	rsp_t due_reports [$];
	rsp_t want_report;

	int unsigned ticks_queued = 0;
	int unsigned idle_pct = IDLE_PCT;
	int unsigned mismatches = 0;
	int unsigned reports_seen = 0;
	longint unsigned cycles = 0;

	// apply one accepted request to the shadow scheduler
	task automatic run_scheduler(input req_t r);
		int unsigned live;
		int unsigned pick;
		int unsigned ndone;
		logic found;
		rsp_t res;
		if (r.req_type == REQ_LOAD) begin
			arr_tab[r.slot] = r.arrival;
			burst_tab[r.slot] = r.burst;
			prio_tab[r.slot] = r.prio;
			left_tab[r.slot] = r.burst;
			done_mark[r.slot] = 1'b0;
			return;
		end
		live = (slot_count > NUM_SLOTS) ? NUM_SLOTS : slot_count;
		found = 1'b0;
		pick = 0;
		ndone = 0;
		res = '0;
		// highest priority among arrived pending slots, earlier arrival then lower slot
		for (int k = 0; k < live; k++) begin
			if (!done_mark[k] && arr_tab[k] <= clock_now) begin
				if (!found || prio_tab[k] > prio_tab[pick] ||
					(prio_tab[k] == prio_tab[pick] && arr_tab[k] < arr_tab[pick])) begin
					pick = k;
					found = 1'b1;
				end
			end
		end
		if (found) begin
			if (left_tab[pick] == burst_tab[pick])
				start_tab[pick] = clock_now;
			if (left_tab[pick] != '0)
				left_tab[pick] = left_tab[pick] - 1'b1;
		end
		if (clock_now != TIME_MAX)
			clock_now = clock_now + 1'b1;
		res.idle = !found;
		res.ran_slot = found ? SLOT_W'(pick) : '0;
		// completion figures
		if (found && left_tab[pick] == '0) begin
			done_mark[pick] = 1'b1;
			res.finished = 1'b1;
			res.completion_time = clock_now;
			res.turnaround = clock_now - TIME_W'(arr_tab[pick]);
			res.waiting = (res.turnaround >= TIME_W'(burst_tab[pick])) ?
				res.turnaround - TIME_W'(burst_tab[pick]) : '0;
			res.response = start_tab[pick] - TIME_W'(arr_tab[pick]);
		end
		for (int k = 0; k < live; k++)
			if (done_mark[k])
				ndone++;
		res.all_done = (ndone == live);
		due_reports.push_back(res);
	endtask

	task automatic check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MISMATCH_SHOWN)
				$display("tick report %0d: %s expected %0d, got %0d",
					reports_seen, field, want, got);
		end
	endtask

	task automatic push_load(input int unsigned s, input int unsigned a,
		input int unsigned b, input int unsigned p);
		req_t it;
		it = '0;
		it.req_type = REQ_LOAD;
		it.slot = SLOT_W'(s);
		it.arrival = ARR_W'(a);
		it.burst = BURST_W'(b);
		it.prio = PRIO_W'(p);
		req_backlog.push_back(it);
	endtask

	// tick payload fields are don't-care, fill them with junk
	task automatic push_ticks(input int unsigned n);
		req_t it;
		repeat (n) begin
			it.req_type = REQ_TICK;
			it.slot = SLOT_W'($urandom);
			it.arrival = ARR_W'($urandom);
			it.burst = BURST_W'($urandom);
			it.prio = PRIO_W'($urandom);
			req_backlog.push_back(it);
			ticks_queued++;
		end
	endtask

	// wait until the block has drained every request and report
	task automatic settle();
		while (req_backlog.size() != 0 || req.valid)
			@(negedge clk);
		while (due_reports.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(input int unsigned v);
		@(posedge clk);
		cfg.data <= CNT_W'(v);
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		slot_count = CNT_W'(v);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	// batches of loads mostly near the current time, interleaved with and followed by a random number of ticks
	task automatic random_phase(input int unsigned count, input int unsigned items);
		int unsigned live, made, n, s, a, b, p, work, t;
		live = (count > NUM_SLOTS) ? NUM_SLOTS : count;
		made = 0;
		while (made < items) begin
			n = $urandom_range(1, 5);
			work = 0;
			repeat (n) begin
				if (live != 0 && $urandom_range(9) < 8)
					s = $urandom_range(live - 1);
				else
					s = $urandom_range(NUM_SLOTS - 1);
				case ($urandom_range(19))
					0: a = $urandom_range(65535);
					1, 2: a = $urandom_range(ticks_queued);
					default: a = ticks_queued + $urandom_range(12);
				endcase
				case ($urandom_range(29))
					0: b = 0;
					1: b = $urandom_range(65535, 1);
					default: b = $urandom_range(6, 1);
				endcase
				p = $urandom_range(1) ? $urandom_range(3) : $urandom_range(255);
				push_load(s, a, b, p);
				made++;
				work += (b > 8) ? 8 : b;
				t = $urandom_range(2);
				push_ticks(t);
				made += t;
			end
			t = $urandom_range(work + 4);
			push_ticks(t);
			made += t;
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready)
				run_scheduler(req.data);
			if (!req.valid || req.ready) begin
				if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
					req.data <= req_backlog.pop_front();
					req.valid <= 1'b1;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// report monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= MISMATCH_SHOWN)
						$display("tick report %0d: no report expected, got slot %0d",
							reports_seen, rsp.data.ran_slot);
				end else begin
					want_report = due_reports.pop_front();
					check_field("idle", want_report.idle, rsp.data.idle);
					check_field("ran_slot", want_report.ran_slot, rsp.data.ran_slot);
					check_field("finished", want_report.finished, rsp.data.finished);
					check_field("completion_time", want_report.completion_time,
						rsp.data.completion_time);
					check_field("turnaround", want_report.turnaround, rsp.data.turnaround);
					check_field("waiting", want_report.waiting, rsp.data.waiting);
					check_field("response", want_report.response, rsp.data.response);
					check_field("all_done", want_report.all_done, rsp.data.all_done);
				end
				reports_seen++;
			end
			rsp.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		foreach (done_mark[k])
			done_mark[k] = 1'b1;
		clock_now = '0;
		slot_count = PCOUNT_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single slot: idle ticks, a slot outside the count, a zero burst
		push_ticks(1);
		push_load(15, 0, 1, 255);
		push_ticks(1);
		push_load(0, 0, 0, 0);
		push_ticks(2);
		settle();

		// full count: ties on arrival and slot, a never-arriving slot, a later high-priority arrival
		write_count(NUM_SLOTS);
		push_load(3, 0, 2, 7);
		push_load(5, 0, 2, 7);
		push_load(2, 2, 1, 7);
		push_load(14, 65535, 65535, 255);
		push_load(7, ticks_queued + 5, 3, 200);
		push_ticks(14);
		settle();

		// random phases over several counts, one of them without idling
		foreach (PHASE_COUNTS[i]) begin
			write_count(PHASE_COUNTS[i]);
			idle_pct = (i == CALM_PHASE) ? 0 : IDLE_PCT;
			random_phase(PHASE_COUNTS[i], PHASE_ITEMS);
			settle();
			idle_pct = IDLE_PCT;
		end

		// longest burst, preempted by a late urgent arrival
		write_count(2);
		push_load(1, 0, 65535, 0);
		push_load(0, ticks_queued + 3, 3, 255);
		push_ticks(8);
		settle();

		if (mismatches == 0 && due_reports.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ preemptive_priority_scheduler.f @@
rtl/core/pps_pkg.sv
rtl/core/pps_if.sv
rtl/core/pps_ctrl.sv
rtl/core/pps_dp.sv
rtl/core/preemptive_priority_scheduler.sv
sim/testbench.sv
